/* design/bfq_pkg.sv */
package bfq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // field widths fixed by the interface
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CAP_W      = 5;
  localparam int COUNT_W    = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIFO_MODE = 2'd0,
    CFG_CAP_LIMIT = 2'd1,
    CFG_RSVD_2    = 2'd2,
    CFG_RSVD_3    = 2'd3
  } cfg_reg_t;

  // broadcast from the controller to the whole row
  typedef struct packed {
    logic shift_left;
    logic shift_right;
    logic load_en;
  } row_cmd_t;

  // what one cell sees
  typedef struct packed {
    logic shift_left;
    logic shift_right;
    logic load;
  } cell_ctl_t;

endpackage

/* design/bfq_cell.sv */
module bfq_cell #(
  parameter int DATA_WIDTH = bfq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  bfq_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] q
);
  import bfq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    priority if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift_left) begin
      data_nxt = right_data;
    end else if (ctl.shift_right) begin
      data_nxt = left_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

/* design/bfq_ctrl.sv */
module bfq_ctrl #(
  parameter int DEPTH      = bfq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bfq_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = $clog2(DEPTH),
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfq_pkg::ACTION_W-1:0]  in_action,
  input  logic [DATA_WIDTH-1:0]         head_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfq_pkg::CFG_DATA_W-1:0] cfg_data,
  output bfq_pkg::row_cmd_t             cmd,
  output logic [IDX_W-1:0]              load_idx,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DATA_WIDTH-1:0]         out_message_out,
  output logic                          out_got_message,
  output logic                          out_dropped_oldest,
  output logic [bfq_pkg::COUNT_W-1:0]   out_entry_count,
  output logic                          out_is_empty
);
  import bfq_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic             lifo_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] msg_r;
  logic                  got_r;
  logic                  drop_r;
  logic [COUNT_W-1:0]    ecount_r;
  logic                  empty_r;

  logic                  accept;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      eff_cap;
  logic [CMP_W-1:0]      cnt_nxt_ext;
  logic                  full;
  logic                  drop;
  logic                  got;
  logic [DATA_WIDTH-1:0] msg;
  logic [CNT_W-1:0]      load_pos;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign cap_ext = CMP_W'(cap_r);
  assign cnt_ext = CMP_W'(count_r);
  // zero or anything above the depth means the full depth
  assign eff_cap = (cap_r == '0 || cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign full    = cnt_ext >= eff_cap;

  always_comb begin
    cmd       = '0;
    load_pos  = '0;
    count_nxt = count_r;
    drop      = 1'b0;
    got       = 1'b0;
    msg       = '0;
    if (accept) begin
      unique case (action_t'(in_action))
        ACT_ENQUEUE: begin
          cmd.load_en = 1'b1;
          drop        = full;
          if (!full) begin
            count_nxt = count_r + 1'b1;
          end
          if (lifo_r) begin
            // push at the front; a dropped back entry falls off the tail
            cmd.shift_right = 1'b1;
          end else begin
            // drop the front by shifting the row toward the head
            cmd.shift_left = full;
            load_pos       = count_r - CNT_W'(full);
          end
        end
        ACT_DEQUEUE: begin
          if (count_r != '0) begin
            cmd.shift_left = 1'b1;
            got            = 1'b1;
            msg            = head_data;
            count_nxt      = count_r - 1'b1;
          end
        end
        ACT_CLEAR: begin
          count_nxt = '0;
        end
        ACT_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign load_idx    = load_pos[IDX_W-1:0];
  assign cnt_nxt_ext = CMP_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifo_r      <= 1'b0;
      cap_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_LIFO_MODE: lifo_r <= cfg_data[0];
          CFG_CAP_LIMIT: cap_r  <= cfg_data[CAP_W-1:0];
          default: begin
          end
        endcase
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg_r    <= msg;
      got_r    <= got;
      drop_r   <= drop;
      ecount_r <= cnt_nxt_ext[COUNT_W-1:0];
      empty_r  <= (count_nxt == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_message_out    = msg_r;
  assign out_got_message    = got_r;
  assign out_dropped_oldest = drop_r;
  assign out_entry_count    = ecount_r;
  assign out_is_empty       = empty_r;

endmodule

/* design/bounded_fifo_lifo_queue.sv */
// Bounded message store, queue or stack order, dropping the oldest entry when full.
// Input channel (in_valid/in_ready): in_action selects enqueue, dequeue, clear or
// size query; in_message_in is the word stored by an enqueue.
// Result channel (out_valid/out_ready): one result per action with the dequeued
// word, got/dropped flags, the entry count and the empty flag after the action.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 lifo_mode,
// index 1 capacity_limit (0 or above DEPTH means DEPTH). Write only while idle.
// Storage is a row of DEPTH cells with the front entry in cell 0; every action
// shifts the whole row by at most one place and loads at most one cell, so an
// action completes in the cycle it is accepted.
// The result is registered: it is valid the cycle after the input transfer.
// Throughput: one action per cycle while out_ready is high, set by the single output register.
// If the receiver stalls, the result holds and in_ready drops until it is taken.
// Reset (rst_n low, synchronous) empties the store, selects queue order and full
// capacity; cell contents are not cleared, no clearing pass is needed.
module bounded_fifo_lifo_queue #(
  parameter int DEPTH      = bfq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bfq_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bfq_pkg::ACTION_W-1:0]   in_action,
  input  logic [DATA_WIDTH-1:0]          in_message_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DATA_WIDTH-1:0]          out_message_out,
  output logic                           out_got_message,
  output logic                           out_dropped_oldest,
  output logic [bfq_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_is_empty,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bfq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  row_cmd_t              cmd;
  logic [IDX_W-1:0]      load_idx;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  bfq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .head_data          (cell_q[0]),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .load_idx           (load_idx),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_message_out    (out_message_out),
    .out_got_message    (out_got_message),
    .out_dropped_oldest (out_dropped_oldest),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    assign ctl.shift_left  = cmd.shift_left;
    assign ctl.shift_right = cmd.shift_right;
    assign ctl.load        = cmd.load_en && (load_idx == IDX_W'(i));

    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_body_l
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_body_r
      assign right_d = cell_q[i+1];
    end

    bfq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_data  (in_message_in),
      .left_data  (left_d),
      .right_data (right_d),
      .q          (cell_q[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_enq_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_ENQUEUE)
      |=> (out_valid && !out_is_empty && !out_got_message))
    else $error("enqueue left the store empty");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_CLEAR)
      |=> (out_valid && out_is_empty && out_entry_count == '0 && !out_dropped_oldest))
    else $error("clear did not empty the store");

  a_drop_only_enq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped_oldest) |-> (!out_got_message && !out_is_empty))
    else $error("drop flagged outside a non-empty enqueue");

  a_no_msg_unless_got: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action != ACT_DEQUEUE)
      |=> (out_message_out == '0 && !out_got_message))
    else $error("message returned by an action other than dequeue");
`endif

endmodule
